[hdl/maf_pkg.sv]
// Shared constants, state encoding and controller/datapath bundles for the moving average filter.
`default_nettype none

package maf_pkg;

    // Default geometry of the sample ring
    localparam int RING_DEPTH_DEF  = 32;
    localparam int SAMPLE_BITS_DEF = 12;

    // Fixed field widths
    localparam int LEN_BITS = 6;
    localparam int AVG_BITS = 12;

    // Window length after reset
    localparam logic [LEN_BITS-1:0] WINDOW_RESET = LEN_BITS'(1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_UPDATE,
        ST_DIVIDE,
        ST_FINISH
    } state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic clear;     // write window register, drop history
        logic capture;   // latch incoming sample
        logic rd;        // read oldest ring entry
        logic upd;       // update ring, sum, slot, count; load divider
        logic step;      // one divider iteration
        logic out_load;  // move quotient into output register
    } dp_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic div_done;
    } dp_stat_t;

endpackage

`default_nettype wire

[hdl/moving_average_filter.sv]
// Top level of the moving average filter: controller and datapath.
// Input channel (in_valid/in_ready, sample) carries one converter reading per
// request; output channel (out_valid/out_ready, average) returns one running
// mean per input request, in order. Config channel (cfg_valid/cfg_ready,
// window_length) writes the window register and drops the sample history; it
// is taken only while the block is idle. A window of zero acts as one; above
// RING_DEPTH it clamps.
// Sequence: a request is captured, the oldest ring entry is read, the sum and
// ring are updated and the restoring divider loaded; the divider produces one
// quotient bit per cycle over SUM_BITS bits (SUM_BITS = SAMPLE_BITS + log2
// depth), the controller sees it finish, and the result is handed off. A new
// request is taken only once the previous result has been handed off.
// Reset: rst_n clears the window to one, the running sum, the slot and the
// fill count; the ring itself is not cleared, slots beyond the fill count read
// as zero.
// Stall: the result sits in an output register, so the next request is taken
// while the receiver stalls; that request then waits at the end of its
// division until the previous result is taken.
`default_nettype none

module moving_average_filter #(
    parameter int RING_DEPTH  = maf_pkg::RING_DEPTH_DEF,
    parameter int SAMPLE_BITS = maf_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [SAMPLE_BITS-1:0]        sample,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic      [maf_pkg::AVG_BITS-1:0]  average,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [maf_pkg::LEN_BITS-1:0]  window_length
);
    import maf_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // Sequence each request: read, update, divide, hand off
    maf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    // Hold ring, running sum and divider
    maf_datapath #(
        .RING_DEPTH  (RING_DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .sample        (sample),
        .window_length (window_length),
        .average       (average)
    );

endmodule

`default_nettype wire

[hdl/maf_datapath.sv]
// Datapath of the moving average filter: sample ring, running sum, fill count and serial divider.
`default_nettype none

module maf_datapath #(
    parameter int RING_DEPTH  = maf_pkg::RING_DEPTH_DEF,
    parameter int SAMPLE_BITS = maf_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire maf_pkg::dp_cmd_t              cmd,
    output maf_pkg::dp_stat_t                  stat,
    input  wire logic [SAMPLE_BITS-1:0]        sample,
    input  wire logic [maf_pkg::LEN_BITS-1:0]  window_length,
    output logic      [maf_pkg::AVG_BITS-1:0]  average
);
    import maf_pkg::*;

    localparam int IDX_BITS  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CNT_BITS  = $clog2(RING_DEPTH + 1);
    localparam int SUM_BITS  = SAMPLE_BITS + IDX_BITS;
    localparam int STEP_BITS = $clog2(SUM_BITS + 1);
    localparam int CMP_BITS  = (LEN_BITS > CNT_BITS) ? LEN_BITS : CNT_BITS;

    logic [SAMPLE_BITS-1:0] ring_mem [RING_DEPTH];

    logic [LEN_BITS-1:0]    window_reg, window_next;
    logic [IDX_BITS-1:0]    slot_reg, slot_next;
    logic [CNT_BITS-1:0]    fill_reg, fill_next;
    logic [SUM_BITS-1:0]    sum_reg, sum_next;
    logic [SAMPLE_BITS-1:0] sample_reg;
    logic [SAMPLE_BITS-1:0] old_reg;

    logic [SUM_BITS-1:0]    quo_reg, quo_next;
    logic [CNT_BITS-1:0]    rem_reg, rem_next;
    logic [CNT_BITS-1:0]    div_reg;
    logic [STEP_BITS-1:0]   cnt_reg, cnt_next;
    logic [AVG_BITS-1:0]    avg_reg;

    logic [CMP_BITS-1:0]    win_ext;
    logic [CNT_BITS-1:0]    eff_win;
    logic [CNT_BITS-1:0]    slot_inc;
    logic                   filling;
    logic [SAMPLE_BITS-1:0] old_val;
    logic [SUM_BITS-1:0]    sum_upd;
    logic [CNT_BITS-1:0]    fill_upd;
    logic [IDX_BITS-1:0]    slot_upd;
    logic [CNT_BITS:0]      trial;
    logic [CNT_BITS:0]      trial_sub;
    logic                   ge;

    // Effective window: zero counts as one, clamp to ring depth
    always_comb
    begin
        win_ext = CMP_BITS'(window_reg);
        if (win_ext == '0)
        begin
            eff_win = CNT_BITS'(1);
        end
        else if (win_ext > CMP_BITS'(RING_DEPTH))
        begin
            eff_win = CNT_BITS'(RING_DEPTH);
        end
        else
        begin
            eff_win = CNT_BITS'(win_ext);
        end
    end

    // Slots not yet written since the last clear read as zero
    always_comb
    begin
        filling  = (fill_reg < eff_win);
        old_val  = filling ? '0 : old_reg;
        sum_upd  = sum_reg - SUM_BITS'(old_val) + SUM_BITS'(sample_reg);
        fill_upd = filling ? fill_reg + CNT_BITS'(1) : fill_reg;
        slot_inc = CNT_BITS'(slot_reg) + CNT_BITS'(1);
        slot_upd = (slot_inc >= eff_win) ? '0 : IDX_BITS'(slot_inc);
    end

    always_comb
    begin
        window_next = window_reg;
        slot_next   = slot_reg;
        fill_next   = fill_reg;
        sum_next    = sum_reg;
        if (cmd.clear)
        begin
            window_next = window_length;
            slot_next   = '0;
            fill_next   = '0;
            sum_next    = '0;
        end
        else if (cmd.upd)
        begin
            slot_next = slot_upd;
            fill_next = fill_upd;
            sum_next  = sum_upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= WINDOW_RESET;
            slot_reg   <= '0;
            fill_reg   <= '0;
            sum_reg    <= '0;
        end
        else
        begin
            window_reg <= window_next;
            slot_reg   <= slot_next;
            fill_reg   <= fill_next;
            sum_reg    <= sum_next;
        end
    end

    // Ring storage, registered read
    always_ff @(posedge clk)
    begin
        if (cmd.upd)
        begin
            ring_mem[slot_reg] <= sample_reg;
        end
        if (cmd.rd)
        begin
            old_reg <= ring_mem[slot_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            sample_reg <= sample;
        end
    end

    // Restoring divider, one quotient bit per cycle
    always_comb
    begin
        trial     = {rem_reg, quo_reg[SUM_BITS-1]};
        trial_sub = trial - {1'b0, div_reg};
        ge        = (trial >= {1'b0, div_reg});
        rem_next  = ge ? CNT_BITS'(trial_sub) : CNT_BITS'(trial);
        quo_next  = {quo_reg[SUM_BITS-2:0], ge};
        cnt_next  = cnt_reg;
        if (cmd.upd)
        begin
            cnt_next = STEP_BITS'(SUM_BITS);
        end
        else if (cmd.step)
        begin
            cnt_next = cnt_reg - STEP_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.upd)
        begin
            quo_reg <= sum_upd;
            rem_reg <= '0;
            div_reg <= fill_upd;
        end
        else if (cmd.step)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
        if (cmd.out_load)
        begin
            avg_reg <= AVG_BITS'(quo_reg);
        end
    end

    assign stat.div_done = (cnt_reg == '0);
    assign average       = avg_reg;

endmodule

`default_nettype wire

[hdl/maf_ctrl.sv]
// Controller state machine of the moving average filter: handshakes and datapath sequencing.
`default_nettype none

module maf_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  wire logic              out_ready,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    output maf_pkg::dp_cmd_t       cmd,
    input  wire maf_pkg::dp_stat_t stat
);
    import maf_pkg::*;

    state_t state_reg, state_next;
    logic   out_full_reg, out_full_next;

    // Next state and output-register occupancy
    always_comb
    begin
        state_next    = state_reg;
        out_full_next = out_full_reg;
        if (out_full_reg && out_ready)
        begin
            out_full_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && !cfg_valid)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                state_next = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                if (stat.div_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!out_full_reg || out_ready)
                begin
                    state_next    = ST_IDLE;
                    out_full_next = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Handshakes and datapath commands
    always_comb
    begin
        in_ready     = 1'b0;
        cfg_ready    = 1'b0;
        cmd          = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready    = !cfg_valid;
                cfg_ready   = 1'b1;
                cmd.clear   = cfg_valid;
                cmd.capture = in_valid && !cfg_valid;
            end
            ST_READ:
            begin
                cmd.rd = 1'b1;
            end
            ST_UPDATE:
            begin
                cmd.upd = 1'b1;
            end
            ST_DIVIDE:
            begin
                cmd.step = !stat.div_done;
            end
            ST_FINISH:
            begin
                cmd.out_load = !out_full_reg || out_ready;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            out_full_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            out_full_reg <= out_full_next;
        end
    end

    assign out_valid = out_full_reg;

endmodule

`default_nettype wire

[hdl/maf_checker.sv]
// Port-level assertions for the moving average filter and the bind that attaches them.
`default_nettype none

module maf_checker #(
    parameter int SAMPLE_BITS = maf_pkg::SAMPLE_BITS_DEF
) (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          in_valid,
    input wire logic                          in_ready,
    input wire logic [SAMPLE_BITS-1:0]        sample,
    input wire logic                          out_valid,
    input wire logic                          out_ready,
    input wire logic [maf_pkg::AVG_BITS-1:0]  average,
    input wire logic                          cfg_valid,
    input wire logic                          cfg_ready,
    input wire logic [maf_pkg::LEN_BITS-1:0]  window_length
);
    import maf_pkg::*;

    // A stalled result holds its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(average))
        else $error("average changed while stalled");

    // Block stays busy through the ring read and sum update after taking a request
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready ##1 !in_ready)
        else $error("request taken while previous still in progress");

    // Config write and input request never share an edge
    a_cfg_excl: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |-> !(in_valid && in_ready))
        else $error("config write collided with input request");

    // No result is shown once reset has been seen at an edge
    a_reset_out: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("out_valid high during reset");

endmodule

bind moving_average_filter maf_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_maf_checker (.*);

`default_nettype wire
